[rtl/core/btk_pkg.sv]
// Shared types and codes for the bounded top-k selection unit.
// No dependencies; imported by btk_cell and bounded_topk_max_heap_unit.
package btk_pkg;

    localparam int KEY_W  = 64;
    localparam int DIST_W = 32;
    localparam int IDX_W  = 32;
    localparam int FUNC_W = 2;
    localparam int CFG_W  = 7;

    // Request kinds carried on s_tuser.
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DRAIN  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // Key layout: distance in the high half, index in the low half, so that
    // one unsigned compare orders by distance and then by index.
    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        key_t     key;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

endpackage

[rtl/core/bounded_topk_max_heap_unit.sv]
// Bounded top-k unit: a sorted chain of CAPACITY cells keeps the smallest keys.
// Insert and clear finish at the accepting edge; a new request is taken every cycle while idle.
// Drain: the unit enters ST_DRAIN and loads results, one per cycle while m_tready is
// high; input is stalled until the drain ends (an empty heap gives one beat, m_tuser low).
// Reset (rst_n low, asynchronous) empties the heap and sets capacity to CAPACITY.
// Depends on btk_pkg and btk_cell.
module bounded_topk_max_heap_unit
    import btk_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,   // capacity
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [KEY_W-1:0]  s_tdata,    // key_dist [31:0], key_index [63:32]
    input  logic [FUNC_W-1:0] s_tuser,    // func [1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [KEY_W-1:0]  m_tdata,    // out_dist [31:0], out_index [63:32]
    output logic              m_tuser,    // out_valid [0]
    output logic              m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);

    state_t             state_reg;
    state_t             state_next;
    logic [CFG_W-1:0]   cap_reg;
    logic [CW-1:0]      fill_reg;
    logic [CW-1:0]      fill_next;
    logic [CW-1:0]      step_reg;
    logic [CW-1:0]      step_next;
    logic               ovalid_reg;
    logic               ovalid_next;
    key_t               okey_reg;
    key_t               okey_next;
    logic               oflag_reg;
    logic               oflag_next;
    logic               olast_reg;
    logic               olast_next;

    cell_ctrl_t         ctrl;
    key_t               cell_key [CAPACITY];
    logic               cell_ins [CAPACITY];
    logic [CFG_W-1:0]   eff_cap;
    logic               full;
    logic               accept;
    logic               load_ok;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign load_ok   = !ovalid_reg || m_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {okey_reg[IDX_W-1:0], okey_reg[KEY_W-1:IDX_W]};
    assign m_tuser  = oflag_reg;
    assign m_tlast  = olast_reg;

    always_comb
    begin
        eff_cap = cap_reg;
        if (cap_reg == '0)
        begin
            eff_cap = CFG_W'(1);
        end
        else if (cap_reg > CFG_W'(CAPACITY))
        begin
            eff_cap = CFG_W'(CAPACITY);
        end
    end

    assign full = CFG_W'(fill_reg) >= eff_cap;

    // Chain of cells; cell 0 holds the smallest key.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        key_t left_key;
        key_t right_key;
        logic left_ins;

        if (i == 0)
        begin : g_head
            assign left_key = ctrl.key;
            assign left_ins = 1'b0;
        end
        else
        begin : g_body
            assign left_key = cell_key[i-1];
            assign left_ins = cell_ins[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign right_key = cell_key[0];
        end
        else
        begin : g_mid
            assign right_key = cell_key[i+1];
        end

        btk_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (CW'(i) < fill_reg),
            .is_tail   ((CW'(i) + CW'(1)) == fill_reg),
            .left_ins  (left_ins),
            .left_key  (left_key),
            .right_key (right_key),
            .head_key  (cell_key[0]),
            .ins       (cell_ins[i]),
            .key       (cell_key[i])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        step_next   = step_reg;
        ovalid_next = ovalid_reg;
        okey_next   = okey_reg;
        oflag_next  = oflag_reg;
        olast_next  = olast_reg;
        ctrl.op     = CELL_HOLD;
        ctrl.key    = {s_tdata[DIST_W-1:0], s_tdata[KEY_W-1:DIST_W]};

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_tuser)
                        FUNC_INSERT:
                        begin
                            // when full, the largest key falls off past the fill point
                            ctrl.op = CELL_INSERT;
                            if (!full)
                            begin
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        FUNC_DRAIN:
                        begin
                            state_next = ST_DRAIN;
                            step_next  = '0;
                        end
                        FUNC_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                            fill_next = fill_reg;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (load_ok)
                begin
                    ovalid_next = 1'b1;
                    if (fill_reg == '0)
                    begin
                        okey_next  = '0;
                        oflag_next = 1'b0;
                        olast_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // emit the head, rotate the chain by one
                        ctrl.op    = CELL_ROTATE;
                        okey_next  = cell_key[0];
                        oflag_next = 1'b1;
                        olast_next = (step_reg + CW'(1)) == fill_reg;
                        step_next  = step_reg + CW'(1);
                        if ((step_reg + CW'(1)) == fill_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cap_reg    <= CFG_W'(CAPACITY);
            fill_reg   <= '0;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        okey_reg  <= okey_next;
        oflag_reg <= oflag_next;
        olast_reg <= olast_next;
    end

endmodule

[rtl/core/btk_cell.sv]
// One cell of the sorted chain: holds one key and exchanges it with its neighbors.
// Depends on btk_pkg.
module btk_cell
    import btk_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       is_tail,
    input  logic       left_ins,
    input  key_t       left_key,
    input  key_t       right_key,
    input  key_t       head_key,
    output logic       ins,
    output key_t       key
);

    key_t key_reg;
    key_t key_next;

    assign ins = !occupied || (ctrl.key < key_reg);
    assign key = key_reg;

    always_comb
    begin
        key_next = key_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (ins)
                begin
                    key_next = left_ins ? left_key : ctrl.key;
                end
            end
            CELL_ROTATE:
            begin
                key_next = is_tail ? head_key : right_key;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule
